[hdl/size_class_buffer_pool_top_defines.svh]
// assertion macros shared by the buffer pool rtl
// depends on nothing; included by files that carry assertions
`ifndef SIZE_CLASS_BUFFER_POOL_TOP_DEFINES_SVH
`define SIZE_CLASS_BUFFER_POOL_TOP_DEFINES_SVH

// same-cycle implication under active low reset
`define SCBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scbp assertion failed");

// next-cycle implication under active low reset
`define SCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scbp assertion failed");

`endif

[hdl/scbp_pkg.sv]
// constants, types and helpers for the size class buffer pool
// no dependencies; used by scbp_mac and size_class_buffer_pool_top
`default_nettype none

package scbp_pkg;

    localparam int NUM_CLASSES    = 3;
    localparam int MAX_SLOTS      = 8;
    localparam int OVERHEAD_BYTES = 36;
    localparam int REG_CLASSES    = 3;
    localparam int ACT_CLASSES    = (NUM_CLASSES < REG_CLASSES) ? NUM_CLASSES : REG_CLASSES;

    localparam int BYTES_W  = 16;
    localparam int CNT_W    = 4;
    localparam int CLS_W    = 2;
    localparam int SLOT_W   = 3;
    localparam int OFS_W    = 24;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = BYTES_W + 1 + CNT_W;

    localparam logic [STATUS_W-1:0] STATUS_GRANT     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOCLASS   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUST   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FREED     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BADHANDLE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CLASS0_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS1_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS2_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS0_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS1_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS2_COUNT = 3'd5;

    localparam logic [BYTES_W-1:0] RESET_BYTES0 = 16'd100;
    localparam logic [BYTES_W-1:0] RESET_BYTES1 = 16'd200;
    localparam logic [BYTES_W-1:0] RESET_BYTES2 = 16'd300;
    localparam logic [CNT_W-1:0]   RESET_COUNT0 = 4'd2;
    localparam logic [CNT_W-1:0]   RESET_COUNT1 = 4'd3;
    localparam logic [CNT_W-1:0]   RESET_COUNT2 = 4'd4;

    typedef logic [BYTES_W-1:0]  bytes_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [OFS_W-1:0]    offset_t;
    typedef logic [MAX_SLOTS-1:0] busy_row_t;

    typedef struct packed {
        logic   clear;
        logic   step;
        bytes_t bytes;
        count_t mult;
    } mac_ctrl_t;

    function automatic count_t eff_count(input count_t n);
        count_t r;
        if (n > count_t'(MAX_SLOTS))
            r = count_t'(MAX_SLOTS);
        else
            r = n;
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/scbp_mac.sv]
// shared multiply-accumulate unit for the buffer offset sum
// depends on scbp_pkg
`default_nettype none

module scbp_mac (
    input  wire logic                clk,
    input  wire scbp_pkg::mac_ctrl_t ctrl,
    output logic [scbp_pkg::OFS_W-1:0] acc
);

    logic [scbp_pkg::OFS_W-1:0]    acc_reg;
    logic [scbp_pkg::OFS_W-1:0]    acc_next;
    logic [scbp_pkg::BYTES_W:0]    stride;
    logic [scbp_pkg::PROD_W-1:0]   prod;

    // buffer stride is data bytes plus header
    assign stride = {1'b0, ctrl.bytes} + (scbp_pkg::BYTES_W+1)'(scbp_pkg::OVERHEAD_BYTES);
    assign prod   = scbp_pkg::PROD_W'(stride) * scbp_pkg::PROD_W'(ctrl.mult);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = scbp_pkg::OFS_W'(scbp_pkg::OVERHEAD_BYTES);
        else if (ctrl.step)
            acc_next = acc_reg + scbp_pkg::OFS_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[hdl/size_class_buffer_pool_top.sv]
// size class buffer pool: allocate and free over three fixed-size classes
// one item is taken at a time; in_stall holds new items until the current one
// is done; a grant walks the classes up to the granted one through the shared
// multiply-accumulate, free and failures skip the walk; a finished beat may wait
// at the output while the next item is taken
// async reset clears all busy marks and loads the default class sizes and counts
`default_nettype none

`include "size_class_buffer_pool_top_defines.svh"

module size_class_buffer_pool_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [scbp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [scbp_pkg::BYTES_W-1:0]        cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                req_type,
    input  wire logic [scbp_pkg::BYTES_W-1:0]        req_size,
    input  wire logic [scbp_pkg::CLS_W-1:0]          free_class,
    input  wire logic [scbp_pkg::SLOT_W-1:0]         free_slot,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [scbp_pkg::STATUS_W-1:0]            status,
    output logic [scbp_pkg::CLS_W-1:0]               grant_class,
    output logic [scbp_pkg::SLOT_W-1:0]              grant_slot,
    output logic [scbp_pkg::OFS_W-1:0]               grant_offset
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_ACC    = 3'd2;
    localparam logic [2:0] ST_FREE   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;

    scbp_pkg::bytes_t bytes_reg [scbp_pkg::REG_CLASSES];
    scbp_pkg::count_t count_reg [scbp_pkg::REG_CLASSES];
    scbp_pkg::busy_row_t busy_reg [scbp_pkg::REG_CLASSES];

    logic                              type_reg;
    logic [scbp_pkg::BYTES_W-1:0]      size_reg;
    logic [scbp_pkg::CLS_W-1:0]        fcls_reg;
    logic [scbp_pkg::SLOT_W-1:0]       fslt_reg;

    logic [scbp_pkg::CLS_W-1:0]        cls_reg, cls_next;
    logic [scbp_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [scbp_pkg::CLS_W-1:0]        step_reg, step_next;
    logic [scbp_pkg::STATUS_W-1:0]     res_reg, res_next;

    logic                              out_valid_reg;
    logic [scbp_pkg::STATUS_W-1:0]     status_reg;
    logic [scbp_pkg::CLS_W-1:0]        gcls_reg;
    logic [scbp_pkg::SLOT_W-1:0]       gslt_reg;
    logic [scbp_pkg::OFS_W-1:0]        gofs_reg;

    logic                              accept;
    logic                              out_free;
    logic                              match_found;
    logic [scbp_pkg::CLS_W-1:0]        match_cls;
    scbp_pkg::count_t                  match_eff;
    logic                              slot_found;
    logic [scbp_pkg::SLOT_W-1:0]       slot_pick;
    scbp_pkg::count_t                  free_eff;
    logic                              free_bad;
    scbp_pkg::mac_ctrl_t               mac_ctrl;
    logic [scbp_pkg::OFS_W-1:0]        mac_acc;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // class match and lowest free slot search
    always_comb
    begin
        match_found = 1'b0;
        match_cls   = '0;
        for (int c = scbp_pkg::ACT_CLASSES - 1; c >= 0; c--)
        begin
            if (bytes_reg[c] == size_reg)
            begin
                match_found = 1'b1;
                match_cls   = scbp_pkg::CLS_W'(c);
            end
        end
        match_eff  = scbp_pkg::eff_count(count_reg[match_cls]);
        slot_found = 1'b0;
        slot_pick  = '0;
        for (int s = scbp_pkg::MAX_SLOTS - 1; s >= 0; s--)
        begin
            if ((scbp_pkg::CNT_W'(s) < match_eff) && !busy_reg[match_cls][s])
            begin
                slot_found = 1'b1;
                slot_pick  = scbp_pkg::SLOT_W'(s);
            end
        end
    end

    // handle check for free requests
    always_comb
    begin
        free_eff = '0;
        for (int c = 0; c < scbp_pkg::ACT_CLASSES; c++)
        begin
            if (fcls_reg == scbp_pkg::CLS_W'(c))
                free_eff = scbp_pkg::eff_count(count_reg[c]);
        end
        free_bad = ({1'b0, fslt_reg} >= free_eff);
    end

    always_comb
    begin
        mac_ctrl.clear = (state_reg == ST_SEARCH);
        mac_ctrl.step  = (state_reg == ST_ACC);
        mac_ctrl.bytes = bytes_reg[step_reg];
        if (step_reg == cls_reg)
            mac_ctrl.mult = scbp_pkg::count_t'(slot_reg);
        else
            mac_ctrl.mult = scbp_pkg::eff_count(count_reg[step_reg]);
    end

    scbp_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .acc  (mac_acc)
    );

    always_comb
    begin
        state_next = state_reg;
        cls_next   = cls_reg;
        slot_next  = slot_reg;
        step_next  = step_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = req_type ? ST_FREE : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cls_next  = match_cls;
                slot_next = slot_pick;
                step_next = '0;
                if (!match_found)
                begin
                    res_next   = scbp_pkg::STATUS_NOCLASS;
                    state_next = ST_DONE;
                end
                else if (!slot_found)
                begin
                    res_next   = scbp_pkg::STATUS_EXHAUST;
                    state_next = ST_DONE;
                end
                else
                begin
                    res_next   = scbp_pkg::STATUS_GRANT;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == cls_reg)
                    state_next = ST_DONE;
            end
            ST_FREE:
            begin
                res_next   = free_bad ? scbp_pkg::STATUS_BADHANDLE : scbp_pkg::STATUS_FREED;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bytes_reg[0]  <= scbp_pkg::RESET_BYTES0;
            bytes_reg[1]  <= scbp_pkg::RESET_BYTES1;
            bytes_reg[2]  <= scbp_pkg::RESET_BYTES2;
            count_reg[0]  <= scbp_pkg::RESET_COUNT0;
            count_reg[1]  <= scbp_pkg::RESET_COUNT1;
            count_reg[2]  <= scbp_pkg::RESET_COUNT2;
            for (int c = 0; c < scbp_pkg::REG_CLASSES; c++)
                busy_reg[c] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    scbp_pkg::REG_CLASS0_BYTES: bytes_reg[0] <= cfg_data;
                    scbp_pkg::REG_CLASS1_BYTES: bytes_reg[1] <= cfg_data;
                    scbp_pkg::REG_CLASS2_BYTES: bytes_reg[2] <= cfg_data;
                    scbp_pkg::REG_CLASS0_COUNT: count_reg[0] <= cfg_data[scbp_pkg::CNT_W-1:0];
                    scbp_pkg::REG_CLASS1_COUNT: count_reg[1] <= cfg_data[scbp_pkg::CNT_W-1:0];
                    scbp_pkg::REG_CLASS2_COUNT: count_reg[2] <= cfg_data[scbp_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_SEARCH && match_found && slot_found)
                busy_reg[match_cls][slot_pick] <= 1'b1;
            if (state_reg == ST_FREE && !free_bad)
                busy_reg[fcls_reg][fslt_reg] <= 1'b0;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg  <= cls_next;
        slot_reg <= slot_next;
        step_reg <= step_next;
        res_reg  <= res_next;
        if (accept)
        begin
            type_reg <= req_type;
            size_reg <= req_size;
            fcls_reg <= free_class;
            fslt_reg <= free_slot;
        end
        // result beat, grant fields zero unless granted
        if (state_reg == ST_DONE && out_free)
        begin
            status_reg <= res_reg;
            if (res_reg == scbp_pkg::STATUS_GRANT)
            begin
                gcls_reg <= cls_reg;
                gslt_reg <= slot_reg;
                gofs_reg <= mac_acc;
            end
            else
            begin
                gcls_reg <= '0;
                gslt_reg <= '0;
                gofs_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign grant_class  = gcls_reg;
    assign grant_slot   = gslt_reg;
    assign grant_offset = gofs_reg;

    `SCBP_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, accept,
        (state_reg == ST_SEARCH && !type_reg) || (state_reg == ST_FREE && type_reg))
    `SCBP_ASSERT_NOW(a_step_bound, clk, rst_n, state_reg == ST_ACC, step_reg <= cls_reg)
    `SCBP_ASSERT_NOW(a_nongrant_zero, clk, rst_n,
        out_valid_reg && status_reg != scbp_pkg::STATUS_GRANT,
        gcls_reg == '0 && gslt_reg == '0 && gofs_reg == '0)
    `SCBP_ASSERT_NEXT(a_done_delivers, clk, rst_n, state_reg == ST_DONE && out_free,
        state_reg == ST_IDLE && out_valid_reg)

endmodule

`default_nettype wire
